// ----- sv/srkx_pkg.sv -----
package srkx_pkg;

  localparam int MAX_KEY_WORDS_DEF = 256;

  localparam int WORD_W      = 32;
  localparam int SLOT_W      = 8;
  localparam int KEY_LEN_W   = 9;
  localparam int PLAIN_W     = 10;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 10;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PLAIN_WORDS = 1'b1;

  localparam logic [KEY_LEN_W-1:0] KEY_LEN_MIN   = 9'd5;
  localparam logic [KEY_LEN_W-1:0] KEY_LEN_MAX   = 9'd256;
  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 9'd130;
  localparam logic [PLAIN_W-1:0]   PLAIN_RESET   = 10'd256;

  // Position verdict for one data word
  typedef struct packed {
    logic              encrypt;
    logic [SLOT_W-1:0] slot;
  } srkx_pos_t;

  function automatic logic [KEY_LEN_W-1:0] eff_len(logic [KEY_LEN_W-1:0] k);
    logic [KEY_LEN_W-1:0] r;
    r = k;
    if (k < KEY_LEN_MIN) r = KEY_LEN_MIN;
    else if (k > KEY_LEN_MAX) r = KEY_LEN_MAX;
    return r;
  endfunction

endpackage

// ----- sv/skewed_repeating_key_xor_core.sv -----
// A data word passes through the s1 register and then the output register before it shows on the output.
// Throughput: one item per cycle, key writes and data words alike, while the output is not held and no reduction runs.
// A key_length write stalls input while the restoring remainder
// unit reduces the stored position to the new length, one bit per cycle.
// Reset (async, active low) clears position and handshake state and loads
// key_length 130 and plain_words 256; the key table holds no reset value.
module skewed_repeating_key_xor_core import srkx_pkg::*; #(
  parameter int MAX_KEY_WORDS = MAX_KEY_WORDS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // key_slot_in[7:0], word_in[39:8]
  input  logic                   s_axis_tuser,  // req_type
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // word_out[31:0], key_slot_used[39:32]
  output logic                   m_axis_tuser   // was_encrypted
);

  logic              in_xfer, data_xfer, key_xfer;
  logic              adv1, adv2, busy;
  srkx_pos_t         pos;
  logic [WORD_W-1:0] key;

  logic              s1_valid_q, s1_enc_q;
  logic [WORD_W-1:0] s1_word_q;
  logic [SLOT_W-1:0] s1_slot_q;
  logic              out_valid_q, out_enc_q;
  logic [WORD_W-1:0] out_word_q;
  logic [SLOT_W-1:0] out_slot_q;

  assign adv2          = !out_valid_q || m_axis_tready;
  assign adv1          = !s1_valid_q || adv2;
  assign s_axis_tready = adv1 && !busy;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign data_xfer     = in_xfer && s_axis_tuser;
  assign key_xfer      = in_xfer && !s_axis_tuser;

  srkx_index u_index (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (data_xfer),
    .last_i     (s_axis_tlast),
    .busy_o     (busy),
    .pos_o      (pos)
  );

  srkx_key_ram #(.DEPTH(MAX_KEY_WORDS)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_xfer),
    .wslot_i (s_axis_tdata[SLOT_W-1:0]),
    .wdata_i (s_axis_tdata[SLOT_W +: WORD_W]),
    .re_i    (adv1),
    .rslot_i (pos.slot),
    .rdata_o (key)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv1) s1_valid_q <= data_xfer;
      if (adv2) out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s1_word_q <= s_axis_tdata[SLOT_W +: WORD_W];
      s1_enc_q  <= pos.encrypt;
      s1_slot_q <= pos.slot;
    end
    if (adv2) begin
      out_word_q <= s1_enc_q ? (s1_word_q ^ key) : s1_word_q;
      out_enc_q  <= s1_enc_q;
      out_slot_q <= s1_slot_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_slot_q, out_word_q};
  assign m_axis_tuser  = out_enc_q;

endmodule

// ----- sv/srkx_key_ram.sv -----
module srkx_key_ram import srkx_pkg::*; #(
  parameter int DEPTH = MAX_KEY_WORDS_DEF
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [SLOT_W-1:0] wslot_i,
  input  logic [WORD_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [SLOT_W-1:0] rslot_i,
  output logic [WORD_W-1:0] rdata_o
);

  localparam int AW = $clog2(DEPTH);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_q;
  logic              oob_q;

  // Drop writes to slots beyond the store
  always_ff @(posedge clk_i) begin
    if (we_i && (32'(wslot_i) < DEPTH)) begin
      mem[AW'(wslot_i)] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[AW'(rslot_i)];
      oob_q   <= !(32'(rslot_i) < DEPTH);
    end
  end

  assign rdata_o = oob_q ? '0 : rdata_q;

endmodule

// ----- sv/srkx_index.sv -----
module srkx_index import srkx_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  item_i,
  input  logic                  last_i,
  output logic                  busy_o,
  output srkx_pos_t             pos_o
);

  logic [KEY_LEN_W-1:0] kl_q, kl_d;
  logic [PLAIN_W-1:0]   plain_words_q, plain_words_d;
  logic [PLAIN_W-1:0]   plain_cnt_q, plain_cnt_d;
  logic [SLOT_W-1:0]    rem_q, rem_d;
  logic [SLOT_W-1:0]    quo_q, quo_d;
  // Position as last stored by an encrypted word, before any length reduction
  logic [SLOT_W-1:0]    raw_rem_q, raw_rem_d;
  logic [SLOT_W-1:0]    raw_quo_q, raw_quo_d;

  logic                 red_busy_q, red_busy_d;
  logic [2:0]           red_cnt_q, red_cnt_d;
  logic [SLOT_W-1:0]    src_r_q, src_r_d, src_q_q, src_q_d;
  logic [SLOT_W-1:0]    acc_r_q, acc_r_d, acc_q_q, acc_q_d;

  logic                 kl_wr;
  logic [KEY_LEN_W-1:0] tr, tq, sum, step_r;
  logic [SLOT_W-1:0]    res_r, res_q;
  logic                 is_plain;
  logic [SLOT_W-1:0]    idx;
  logic [KEY_LEN_W-1:0] q_inc;

  assign kl_wr = cfg_we_i && (cfg_idx_i == REG_KEY_LENGTH);

  // One restoring step per cycle on both remainder and quotient
  always_comb begin
    tr    = {acc_r_q, src_r_q[SLOT_W-1]};
    tq    = {acc_q_q, src_q_q[SLOT_W-1]};
    res_r = (tr >= kl_q) ? SLOT_W'(tr - kl_q) : SLOT_W'(tr);
    res_q = (tq >= kl_q) ? SLOT_W'(tq - kl_q) : SLOT_W'(tq);
  end

  assign is_plain = plain_cnt_q < plain_words_q;

  always_comb begin
    sum   = {1'b0, rem_q} + {1'b0, quo_q};
    idx   = (sum >= kl_q) ? SLOT_W'(sum - kl_q) : SLOT_W'(sum);
    step_r = {1'b0, rem_q} + KEY_LEN_W'(4);
    q_inc = {1'b0, quo_q} + KEY_LEN_W'(1);
  end

  always_comb begin
    kl_d          = kl_q;
    plain_words_d = plain_words_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_KEY_LENGTH:  kl_d = eff_len(cfg_data_i[KEY_LEN_W-1:0]);
        REG_PLAIN_WORDS: plain_words_d = cfg_data_i[PLAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    plain_cnt_d = plain_cnt_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    raw_rem_d   = raw_rem_q;
    raw_quo_d   = raw_quo_q;
    red_busy_d  = red_busy_q;
    red_cnt_d   = red_cnt_q;
    src_r_d     = src_r_q;
    src_q_d     = src_q_q;
    acc_r_d     = acc_r_q;
    acc_q_d     = acc_q_q;
    if (kl_wr) begin
      // Restart from the stored position on every length write
      red_busy_d = 1'b1;
      red_cnt_d  = '0;
      src_r_d    = raw_rem_q;
      src_q_d    = raw_quo_q;
      acc_r_d    = '0;
      acc_q_d    = '0;
    end else if (red_busy_q) begin
      src_r_d   = src_r_q << 1;
      src_q_d   = src_q_q << 1;
      acc_r_d   = res_r;
      acc_q_d   = res_q;
      red_cnt_d = red_cnt_q + 3'd1;
      if (red_cnt_q == 3'd7) begin
        red_busy_d = 1'b0;
        rem_d      = res_r;
        quo_d      = res_q;
      end
    end else if (item_i) begin
      if (is_plain) begin
        plain_cnt_d = plain_cnt_q + PLAIN_W'(1);
      end else begin
        if (step_r >= kl_q) begin
          rem_d = SLOT_W'(step_r - kl_q);
          quo_d = (q_inc == kl_q) ? '0 : SLOT_W'(q_inc);
        end else begin
          rem_d = SLOT_W'(step_r);
        end
        raw_rem_d = rem_d;
        raw_quo_d = quo_d;
      end
      if (last_i) begin
        plain_cnt_d = '0;
        rem_d       = '0;
        quo_d       = '0;
        raw_rem_d   = '0;
        raw_quo_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kl_q          <= KEY_LEN_RESET;
      plain_words_q <= PLAIN_RESET;
      plain_cnt_q   <= '0;
      rem_q         <= '0;
      quo_q         <= '0;
      raw_rem_q     <= '0;
      raw_quo_q     <= '0;
      red_busy_q    <= 1'b0;
      red_cnt_q     <= '0;
    end else begin
      kl_q          <= kl_d;
      plain_words_q <= plain_words_d;
      plain_cnt_q   <= plain_cnt_d;
      rem_q         <= rem_d;
      quo_q         <= quo_d;
      raw_rem_q     <= raw_rem_d;
      raw_quo_q     <= raw_quo_d;
      red_busy_q    <= red_busy_d;
      red_cnt_q     <= red_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_r_q <= src_r_d;
    src_q_q <= src_q_d;
    acc_r_q <= acc_r_d;
    acc_q_q <= acc_q_d;
  end

  assign busy_o        = red_busy_q;
  assign pos_o.encrypt = !is_plain;
  assign pos_o.slot    = is_plain ? '0 : idx;

endmodule

// ----- sv/srkx_checker.sv -----
module srkx_checker import srkx_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   cfg_we_i,
  input logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   s_axis_tuser,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tuser
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled output changed");

  a_plain_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[OUT_TDATA_W-1:WORD_W] == '0)
    else $error("plain word carries a key slot");

  a_rise_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tuser, 2))
    else $error("output appeared without a data transfer");

  a_len_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i == REG_KEY_LENGTH) |=> !s_axis_tready)
    else $error("input taken during key length reduction");

endmodule

bind skewed_repeating_key_xor_core srkx_checker u_srkx_checker (.*);

// ----- tb/skewed_repeating_key_xor_core_tb.sv -----
`timescale 1ns / 1ps

module skewed_repeating_key_xor_core_tb;
  import srkx_pkg::*;

  localparam logic REQ_KEY  = 1'b0;
  localparam logic REQ_DATA = 1'b1;

  localparam int RESET_CYCLES   = 10;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 220;
  localparam int MAX_REPORTS    = 10;
  localparam int KEY_SLOTS      = MAX_KEY_WORDS_DEF;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;
  typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_BURSTY} rx_mode_e;

  typedef struct packed {
    logic              req;
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] word;
    logic              last;
  } stream_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              encrypted;
    logic [SLOT_W-1:0] slot;
  } cipher_word_t;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    stream_item_t          item;
    logic                  typed;
    cipher_word_t          result;
  } stim_row_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // key_slot_in[7:0], word_in[39:8]
  logic                   s_axis_tuser  = 1'b0;  // req_type
  logic                   s_axis_tlast  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;  // word_out[31:0], key_slot_used[39:32]
  logic                   m_axis_tuser;  // was_encrypted

  skewed_repeating_key_xor_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  // Predictor state
  logic [WORD_W-1:0]    key_table [KEY_SLOTS];
  logic [KEY_LEN_W-1:0] key_len_q;
  logic [PLAIN_W-1:0]   plain_words_q;
  logic [PLAIN_W-1:0]   plain_cnt_q;
  int unsigned          offset_rem_q;
  int unsigned          offset_quo_q;
  cipher_word_t         expected_words [$];

  // Stimulus pacing
  rx_mode_e rx_mode = RX_COIN;
  bit       rx_stall = 1'b0;
  int       rx_run = 0;
  bit       tx_gaps = 1'b1;
  int       burst_left = 0;

  int n_key_writes = 0;
  int n_data_words = 0;
  int n_encrypted  = 0;
  int n_cfg_writes = 0;
  int n_mismatch   = 0;
  int idle_cycles  = 0;

  cipher_word_t got_word;
  cipher_word_t want_word;

  function automatic cipher_word_t predict_cipher_word(stream_item_t it);
    cipher_word_t res;
    int unsigned  klen;
    int unsigned  rem;
    int unsigned  quo;
    int unsigned  idx;
    int unsigned  nxt;
    res = '0;
    if (plain_cnt_q < plain_words_q) begin
      plain_cnt_q = plain_cnt_q + 1'b1;
      res.word    = it.word;
    end else begin
      klen = 32'(key_len_q);
      if (klen < KEY_LEN_MIN) klen = 32'(KEY_LEN_MIN);
      else if (klen > KEY_LEN_MAX) klen = 32'(KEY_LEN_MAX);
      // reduce first: the length may have changed since the last word
      rem = offset_rem_q % klen;
      quo = offset_quo_q % klen;
      idx = (rem + quo) % klen;
      nxt = rem + 4;
      if (nxt >= klen) begin
        nxt = nxt - klen;
        quo = (quo + 1) % klen;
      end
      offset_rem_q  = nxt & 8'hFF;
      offset_quo_q  = quo & 8'hFF;
      res.word      = it.word ^ key_table[idx[SLOT_W-1:0]];
      res.encrypted = 1'b1;
      res.slot      = idx[SLOT_W-1:0];
    end
    if (it.last) begin
      plain_cnt_q  = '0;
      offset_rem_q = 0;
      offset_quo_q = 0;
    end
    return res;
  endfunction

  function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] val);
    stim_row_t row;
    row         = '0;
    row.kind    = ROW_CFG;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  function automatic stim_row_t key_row(logic [SLOT_W-1:0] slot, logic [WORD_W-1:0] word,
                                        logic last);
    stim_row_t row;
    row      = '0;
    row.kind = ROW_ITEM;
    row.item = '{req: REQ_KEY, slot: slot, word: word, last: last};
    return row;
  endfunction

  function automatic stim_row_t data_row(logic [WORD_W-1:0] word, logic last);
    stim_row_t row;
    row      = '0;
    row.kind = ROW_ITEM;
    row.item = '{req: REQ_DATA, slot: '0, word: word, last: last};
    return row;
  endfunction

  // Plain region: the word passes unchanged with no slot
  function automatic stim_row_t plain_row(logic [WORD_W-1:0] word, logic last);
    stim_row_t row;
    row        = data_row(word, last);
    row.typed  = 1'b1;
    row.result = '{word: word, encrypted: 1'b0, slot: '0};
    return row;
  endfunction

  function automatic stream_item_t random_item();
    stream_item_t it;
    it.req  = ($urandom_range(0, 9) == 0) ? REQ_KEY : REQ_DATA;
    it.slot = SLOT_W'($urandom_range(0, KEY_SLOTS - 1));
    it.word = $urandom();
    it.last = ($urandom_range(0, 11) == 0);
    return it;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_key_length();
    case ($urandom_range(0, 7))
      0:       return CFG_DATA_W'(KEY_LEN_MIN);
      1:       return CFG_DATA_W'(KEY_LEN_MAX);
      2:       return CFG_DATA_W'($urandom_range(0, 4));
      3:       return CFG_DATA_W'($urandom_range(257, 511));
      default: return CFG_DATA_W'($urandom_range(5, 256));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_plain_words();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 10'd1023;
      2:       return CFG_DATA_W'($urandom_range(0, 1023));
      3:       return CFG_DATA_W'($urandom_range(0, 40));
      default: return CFG_DATA_W'($urandom_range(0, 6));
    endcase
  endfunction

  // Hold off until every result is out, then let in-flight key writes settle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    s_axis_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_KEY_LENGTH) key_len_q = val[KEY_LEN_W-1:0];
    else plain_words_q = val[PLAIN_W-1:0];
    n_cfg_writes++;
  endtask

  task automatic push_item(stream_item_t it, logic typed, cipher_word_t typed_res);
    cipher_word_t res;
    int           gap;
    if (tx_gaps && burst_left == 0) begin
      gap = $urandom_range(1, 16);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {it.word, it.slot};
    s_axis_tuser  <= it.req;
    s_axis_tlast  <= it.last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (burst_left > 0) burst_left--;
    if (it.req == REQ_KEY) begin
      key_table[it.slot] = it.word;
      n_key_writes++;
    end else begin
      res = predict_cipher_word(it);
      if (typed) res = typed_res;
      expected_words.push_back(res);
      n_data_words++;
    end
  endtask

  task automatic note_mismatch(string what, cipher_word_t want, cipher_word_t got);
    n_mismatch++;
    if (n_mismatch <= MAX_REPORTS)
      $display("mismatch, %s: expected word %h enc %0b slot %0d, got word %h enc %0b slot %0d",
               what, want.word, want.encrypted, want.slot, got.word, got.encrypted, got.slot);
  endtask

  // Receiver stall pattern
  always @(posedge clk_i) begin
    case (rx_mode)
      RX_ALWAYS: m_axis_tready <= 1'b1;
      RX_COIN:   m_axis_tready <= ($urandom_range(0, 1) == 1);
      RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 7) != 0);
      default: begin
        if (rx_run == 0) begin
          rx_stall = !rx_stall;
          rx_run   = rx_stall ? $urandom_range(1, 40) : $urandom_range(1, 12);
        end else begin
          rx_run--;
        end
        m_axis_tready <= !rx_stall;
      end
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_word = {m_axis_tdata[WORD_W-1:0], m_axis_tuser, m_axis_tdata[WORD_W+SLOT_W-1:WORD_W]};
      if (got_word.encrypted) n_encrypted++;
      if (expected_words.size() == 0) begin
        note_mismatch("result with nothing pending", '0, got_word);
      end else begin
        want_word = expected_words.pop_front();
        if (got_word.word !== want_word.word ||
            got_word.encrypted !== want_word.encrypted ||
            got_word.slot !== want_word.slot)
          note_mismatch("field differs", want_word, got_word);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("watchdog: no transfer for %0d cycles, %0d results pending",
             WATCHDOG_LIMIT, expected_words.size());
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    stim_row_t    directed [$];
    stream_item_t it;
    cipher_word_t no_res;
    int           n_random;
    int           phase_items;

    no_res        = '0;
    n_random      = 0;
    key_len_q     = KEY_LEN_RESET;
    plain_words_q = PLAIN_RESET;
    plain_cnt_q   = '0;
    offset_rem_q  = 0;
    offset_quo_q  = 0;

    // Reset defaults: plain words pass, last on a key write is ignored
    directed.push_back(plain_row(32'h0000_0000, 1'b0));
    directed.push_back(plain_row(32'hFFFF_FFFF, 1'b0));
    directed.push_back(key_row(8'hFF, 32'hFFFF_FFFF, 1'b1));
    directed.push_back(key_row(8'h00, 32'h0000_0000, 1'b0));
    directed.push_back(plain_row(32'h1234_5678, 1'b1));
    // Shortest key, length below range, wraps of remainder and quotient
    directed.push_back(cfg_row(REG_PLAIN_WORDS, 10'd0));
    directed.push_back(cfg_row(REG_KEY_LENGTH, 10'd0));
    directed.push_back(data_row(32'hA5A5_A5A5, 1'b0));
    directed.push_back(data_row(32'hFFFF_FFFF, 1'b0));
    directed.push_back(data_row(32'h0000_0000, 1'b0));
    directed.push_back(data_row(32'h5A5A_5A5A, 1'b0));
    directed.push_back(data_row(32'h8000_0001, 1'b0));
    directed.push_back(data_row(32'h7FFF_FFFE, 1'b1));
    // Length above range acts as the longest key
    directed.push_back(cfg_row(REG_KEY_LENGTH, 10'd511));
    directed.push_back(data_row(32'hDEAD_BEEF, 1'b0));
    directed.push_back(data_row(32'hC0DE_CAFE, 1'b1));
    directed.push_back(cfg_row(REG_PLAIN_WORDS, 10'd1023));
    directed.push_back(cfg_row(REG_KEY_LENGTH, 10'd256));
    directed.push_back(plain_row(32'h0F0F_0F0F, 1'b1));
    // Mid-file changes of both registers
    directed.push_back(cfg_row(REG_PLAIN_WORDS, 10'd2));
    directed.push_back(plain_row(32'h1111_1111, 1'b0));
    directed.push_back(plain_row(32'h2222_2222, 1'b0));
    directed.push_back(data_row(32'h3333_3333, 1'b0));
    directed.push_back(data_row(32'h4444_4444, 1'b0));
    directed.push_back(data_row(32'h5555_5555, 1'b0));
    directed.push_back(cfg_row(REG_KEY_LENGTH, 10'd7));
    directed.push_back(data_row(32'h6666_6666, 1'b0));
    directed.push_back(data_row(32'h7777_7777, 1'b0));
    directed.push_back(cfg_row(REG_PLAIN_WORDS, 10'd5));
    directed.push_back(plain_row(32'h8888_8888, 1'b0));
    directed.push_back(plain_row(32'h9999_9999, 1'b1));

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill the whole key table so no read ever hits an unwritten slot
    for (int s = 0; s < KEY_SLOTS; s++) begin
      it      = random_item();
      it.req  = REQ_KEY;
      it.slot = SLOT_W'(s);
      push_item(it, 1'b0, no_res);
    end

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG)
        write_reg(directed[i].reg_idx, directed[i].reg_val);
      else
        push_item(directed[i].item, directed[i].typed, directed[i].result);
    end

    while (n_random < RANDOM_ITEMS) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      tx_gaps = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) != 0) write_reg(REG_KEY_LENGTH, pick_key_length());
      if ($urandom_range(0, 3) != 0) write_reg(REG_PLAIN_WORDS, pick_plain_words());
      phase_items = $urandom_range(15, 60);
      repeat (phase_items) begin
        push_item(random_item(), 1'b0, no_res);
        n_random++;
      end
    end

    s_axis_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d key writes and %0d data words, %0d of them encrypted,",
             n_key_writes, n_data_words, n_encrypted);
    $display("across %0d register writes; %0d mismatches", n_cfg_writes, n_mismatch);
    if (n_mismatch == 0 && expected_words.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
